>>> rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and the character table of the base64url stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int GROUP_W  = 6;
    localparam int SYMBOL_W = 7;
    localparam int BYTE_W   = 8;
    localparam int BUS_W    = 8;

    // Alphabet boundaries
    localparam logic [GROUP_W-1:0] IDX_LOWER = 6'd26;
    localparam logic [GROUP_W-1:0] IDX_DIGIT = 6'd52;
    localparam logic [GROUP_W-1:0] IDX_DASH  = 6'd62;

    localparam logic [SYMBOL_W-1:0] CHR_UPPER_A = 7'h41;
    localparam logic [SYMBOL_W-1:0] CHR_LOWER_A = 7'h61;
    localparam logic [SYMBOL_W-1:0] CHR_ZERO    = 7'h30;
    localparam logic [SYMBOL_W-1:0] CHR_DASH    = 7'h2D;
    localparam logic [SYMBOL_W-1:0] CHR_UNDER   = 7'h5F;

    // One classified byte: the groups it yields and how to close them
    typedef struct packed {
        logic [GROUP_W-1:0] group0;
        logic [GROUP_W-1:0] group1;
        logic               two;      // group1 is emitted as well
        logic               last;     // closes the message
    } b64e_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } b64e_qstat_t;

    // Map a 6-bit group to its base64url ASCII code
    function automatic logic [SYMBOL_W-1:0] b64e_char(input logic [GROUP_W-1:0] idx);
        logic [SYMBOL_W-1:0] ext;
        ext = {1'b0, idx};
        if (idx < IDX_LOWER) begin
            b64e_char = CHR_UPPER_A + ext;
        end else if (idx < IDX_DIGIT) begin
            b64e_char = CHR_LOWER_A + ext - {1'b0, IDX_LOWER};
        end else if (idx < IDX_DASH) begin
            b64e_char = CHR_ZERO + ext - {1'b0, IDX_DIGIT};
        end else if (idx == IDX_DASH) begin
            b64e_char = CHR_DASH;
        end else begin
            b64e_char = CHR_UNDER;
        end
    endfunction

endpackage

>>> rtl/base64url_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64url_stream_encoder_top
// Unpadded base64url encoder for a byte stream.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ stream, tlast marking the final byte of a message;
// characters leave on the m_ stream as ASCII in tdata[6:0], tlast set on the
// last character a byte produces and tuser set on the last character of the
// message. A byte yields one or two characters; the result port moves one
// character per cycle while m_tready is high and the queue is not empty,
// through the single output register of the back end. A two-entry queue
// between the byte classifier and the character output lets input and
// output stall independently; the first character of a byte passes through
// a queue slot and then the output register.
module base64url_stream_encoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] symbol, [7] zero
    output logic       m_tlast,   // end_of_run
    output logic       m_tuser    // end_of_message
);
    import b64e_pkg::*;

    b64e_qstat_t         qstat;
    b64e_entry_t         push_entry, pop_entry;
    logic                push, pop;
    logic [SYMBOL_W-1:0] symbol;

    b64e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .s_final    (s_tlast),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    b64e_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_symbol  (symbol),
        .m_run_end (m_tlast),
        .m_msg_end (m_tuser)
    );

    assign m_tdata = {{(BUS_W-SYMBOL_W){1'b0}}, symbol};

endmodule

>>> rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, merges them with held bits and splits them into
// the 6-bit groups to emit; pushes one queue entry per byte.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [b64e_pkg::BYTE_W-1:0] s_byte,
    input  logic                   s_final,
    input  b64e_pkg::b64e_qstat_t  qstat,
    output logic                   push,
    output b64e_pkg::b64e_entry_t  push_entry
);
    import b64e_pkg::*;

    localparam logic [2:0] HELD_0 = 3'd0;
    localparam logic [2:0] HELD_2 = 3'd2;
    localparam logic [2:0] HELD_4 = 3'd4;

    logic [3:0] bits_reg, bits_next;
    logic [2:0] count_reg, count_next;

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    // Classify the byte against the held bits
    always_comb begin
        push_entry.last = s_final;
        unique case (count_reg)
            HELD_2: begin
                push_entry.group0 = {bits_reg[1:0], s_byte[7:4]};
                push_entry.group1 = {s_byte[3:0], 2'b00};
                push_entry.two    = s_final;
                bits_next         = s_byte[3:0];
                count_next        = HELD_4;
            end
            HELD_4: begin
                push_entry.group0 = {bits_reg[3:0], s_byte[7:6]};
                push_entry.group1 = s_byte[5:0];
                push_entry.two    = 1'b1;
                bits_next         = 4'd0;
                count_next        = HELD_0;
            end
            default: begin
                push_entry.group0 = s_byte[7:2];
                push_entry.group1 = {s_byte[1:0], 4'b0000};
                push_entry.two    = s_final;
                bits_next         = {2'b00, s_byte[1:0]};
                count_next        = HELD_2;
            end
        endcase
        // Clear held bits after the final byte
        if (s_final) begin
            bits_next  = 4'd0;
            count_next = HELD_0;
        end
    end

    // Hold leftover bits between bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg  <= 4'd0;
            count_reg <= HELD_0;
        end else if (push) begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module b64e_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64e_pkg::b64e_entry_t push_entry,
    input  logic                  pop,
    output b64e_pkg::b64e_entry_t pop_entry,
    output b64e_pkg::b64e_qstat_t qstat
);
    import b64e_pkg::*;

    b64e_entry_t slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;

    assign pop_entry   = slot_reg[rd_ptr_reg];
    assign qstat.full  = fill_reg[1];
    assign qstat.empty = (fill_reg == 2'd0);

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

>>> rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Drains queue entries into characters, one per cycle unless m_tready stalls
// the output, through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b64e_pkg::b64e_qstat_t qstat,
    input  b64e_pkg::b64e_entry_t pop_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [b64e_pkg::SYMBOL_W-1:0] m_symbol,
    output logic                  m_run_end,
    output logic                  m_msg_end
);
    import b64e_pkg::*;

    typedef enum logic {PH_FIRST, PH_SECOND} phase_t;

    phase_t              phase_reg;
    logic                valid_reg;
    logic [SYMBOL_W-1:0] symbol_reg;
    logic                run_end_reg, msg_end_reg;
    logic                load;

    assign load     = (!valid_reg || m_tready) && !qstat.empty;
    assign pop      = load && (phase_reg == PH_SECOND || !pop_entry.two);
    assign m_tvalid = valid_reg;
    assign m_symbol = symbol_reg;
    assign m_run_end = run_end_reg;
    assign m_msg_end = msg_end_reg;

    // Hold phase and the registered character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                unique case (phase_reg)
                    PH_FIRST:  phase_reg <= pop_entry.two ? PH_SECOND : PH_FIRST;
                    PH_SECOND: phase_reg <= PH_FIRST;
                    default:   phase_reg <= PH_FIRST;
                endcase
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load character payload
    always_ff @(posedge aclk) begin
        if (load) begin
            if (phase_reg == PH_SECOND) begin
                symbol_reg  <= b64e_char(pop_entry.group1);
                run_end_reg <= 1'b1;
                msg_end_reg <= pop_entry.last;
            end else begin
                symbol_reg  <= b64e_char(pop_entry.group0);
                run_end_reg <= !pop_entry.two;
                msg_end_reg <= !pop_entry.two && pop_entry.last;
            end
        end
    end

endmodule

>>> rtl/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level assertions for the base64url stream encoder.
// ----------------------------------------------------------------------------
module b64e_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Hold a stalled character
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled character changed");

    // Message end always closes a run
    a_msg_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of message without end of run");

    // Characters are 7-bit ASCII
    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("symbol outside 7-bit range");

    // Nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind base64url_stream_encoder_top b64e_checker u_b64e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
